/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, operation and status codes and the command record for
// the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 2'd0,
        K_PUSH_BACK  = 2'd1,
        K_POP_FRONT  = 2'd2,
        K_POP_BACK   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // one classified operation for the storage side
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_cmd;

endpackage

/* rtl/core/bdq_front.sv */
// ----------------------------------------------------------------------------
// bdq_front
// Accepts operations, keeps the front pointer and element count, refuses
// pushes when full and pops when empty, and issues slot commands.
// ----------------------------------------------------------------------------
module bdq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bdq_pkg::KIND_W-1:0]  i_kind,
    input  logic [bdq_pkg::DATA_W-1:0]  i_push_value,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output bdq_pkg::t_cmd               o_cmd
);
    import bdq_pkg::*;

    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_take;
    logic             w_full;
    logic             w_empty;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_sum_m1;
    logic [IDX_W-1:0] w_back_slot;
    logic [IDX_W-1:0] w_last_slot;
    logic [IDX_W-1:0] w_prev_front;
    logic [IDX_W-1:0] w_next_front;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign w_take      = i_valid && i_cmd_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    // slot offsets wrap with one compare and subtract
    assign w_sum       = SUM_W'(r_front) + SUM_W'(r_count);
    assign w_sum_m1    = w_sum - SUM_W'(1);
    assign w_back_slot = (w_sum >= SUM_W'(DEPTH)) ? IDX_W'(w_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(w_sum);
    assign w_last_slot = (w_sum_m1 >= SUM_W'(DEPTH)) ? IDX_W'(w_sum_m1 - SUM_W'(DEPTH))
                                                     : IDX_W'(w_sum_m1);
    assign w_prev_front = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);
    assign w_next_front = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + IDX_W'(1);

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        o_cmd.wr     = 1'b0;
        o_cmd.rd     = 1'b0;
        o_cmd.addr   = r_front;
        o_cmd.data   = i_push_value;
        o_cmd.status = ST_OK;
        case (t_kind'(i_kind))
            K_PUSH_FRONT: begin
                if (w_full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.addr = w_prev_front;
                    n_front    = w_prev_front;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            K_PUSH_BACK: begin
                if (w_full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.addr = w_back_slot;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            K_POP_FRONT: begin
                if (w_empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.addr = r_front;
                    n_front    = w_next_front;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            K_POP_BACK: begin
                if (w_empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.addr = w_last_slot;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                o_cmd.status = ST_OK;
            end
        endcase
        o_cmd.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (w_take) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_cmd.status != ST_OK) |=> ($stable(r_count) && $stable(r_front)))
        else $error("refused operation changed the queue state");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> !(o_cmd.wr && o_cmd.rd) &&
                        ((o_cmd.wr || o_cmd.rd) == (o_cmd.status == ST_OK)))
        else $error("command access flags disagree with status");

endmodule

/* rtl/core/bdq_cmd_q.sv */
// ----------------------------------------------------------------------------
// bdq_cmd_q
// Two-entry command queue between the classifier and the storage side.
// ----------------------------------------------------------------------------
module bdq_cmd_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bdq_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output bdq_pkg::t_cmd o_cmd
);
    import bdq_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("command queue fill beyond two");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0 || r_fill == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill level");

endmodule

/* rtl/core/bdq_back.sv */
// ----------------------------------------------------------------------------
// bdq_back
// Slot store and result register: carries out writes and reads and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module bdq_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bdq_pkg::t_cmd               i_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bdq_pkg::DATA_W-1:0]  o_pop_value,
    output logic [bdq_pkg::STAT_W-1:0]  o_status,
    output logic [bdq_pkg::CNT_W-1:0]   o_count
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] r_slot_store [DEPTH];
    logic              r_valid;
    logic [DATA_W-1:0] r_pop;
    t_status           r_status;
    logic [CNT_W-1:0]  r_count;
    logic              w_take;

    assign o_ready     = !r_valid || i_ready;
    assign w_take      = i_valid && o_ready;
    assign o_valid     = r_valid;
    assign o_pop_value = r_pop;
    assign o_status    = r_status;
    assign o_count     = r_count;

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_take && i_cmd.wr) begin
            r_slot_store[i_cmd.addr] <= i_cmd.data;
        end
        if (w_take) begin
            r_pop    <= i_cmd.rd ? r_slot_store[i_cmd.addr] : '0;
            r_status <= i_cmd.status;
            r_count  <= i_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

/* rtl/core/bounded_deque_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_top
// Double-ended queue of sixteen 32-bit elements in a circular slot store.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_ready with i_kind (0 push front, 1 push back,
//   2 pop front, 3 pop back) and i_push_value, ignored on pops
//   output channel: o_valid / i_ready with o_pop_value (zero unless a pop
//   succeeded), o_status (0 ok, 1 push refused as full, 2 pop refused as
//   empty) and o_element_count, the count after the operation
//   every input transfer gives exactly one output transfer, in order
// timing
//   a result passes through the command queue and then the store read
//   register; throughput: one transfer per cycle while i_ready is high;
//   the classifier resolves pointer and count in the accepting cycle,
//   and the store has one access per cycle
// reset
//   synchronous, active low; the queue comes out empty with the front
//   pointer at slot zero; the slot store itself is not cleared
// stalls
//   when i_ready is low the result register holds, the two-entry command
//   queue fills and then o_ready falls until the receiver takes a transfer
// ----------------------------------------------------------------------------
module bounded_deque_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bdq_pkg::KIND_W-1:0]  i_kind,
    input  logic [bdq_pkg::DATA_W-1:0]  i_push_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bdq_pkg::DATA_W-1:0]  o_pop_value,
    output logic [bdq_pkg::STAT_W-1:0]  o_status,
    output logic [bdq_pkg::CNT_W-1:0]   o_element_count
);
    import bdq_pkg::*;

    // classifier to queue
    logic w_fr_valid;
    logic w_fr_ready;
    t_cmd w_fr_cmd;

    // queue to storage side
    logic w_bk_valid;
    logic w_bk_ready;
    t_cmd w_bk_cmd;

    // front: pointer and count bookkeeping, refusal of full and empty cases
    bdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .o_cmd_valid  (w_fr_valid),
        .i_cmd_ready  (w_fr_ready),
        .o_cmd        (w_fr_cmd)
    );

    // short queue so front and back stall independently
    bdq_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_cmd   (w_fr_cmd),
        .o_valid (w_bk_valid),
        .i_ready (w_bk_ready),
        .o_cmd   (w_bk_cmd)
    );

    // back: slot store access and result register
    bdq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_bk_valid),
        .o_ready     (w_bk_ready),
        .i_cmd       (w_bk_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pop_value (o_pop_value),
        .o_status    (o_status),
        .o_count     (o_element_count)
    );

endmodule
